// ===== sv/fls_pkg.sv =====
// Shared widths, request and status codes, and register map for the slot allocator.
package fls_pkg;

  localparam int unsigned DEFAULT_POOL_DEPTH = 1024;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned POOL_W  = 8;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned BYTES_W = 13;
  localparam int unsigned OFF_W   = 22;
  localparam int unsigned STAT_W  = 2;

  localparam int unsigned APB_DW  = 32;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned RIDX_W  = 2;

  localparam logic [BYTES_W-1:0] BYTES_MAX = BYTES_W'(4096);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TRANSLATE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD   = 2'd2;

  // Register indexes
  localparam logic [RIDX_W-1:0] REG_POOL_TAG   = 2'd0;
  localparam logic [RIDX_W-1:0] REG_SLOT_COUNT = 2'd1;
  localparam logic [RIDX_W-1:0] REG_SLOT_BYTES = 2'd2;

  // Register reset values
  localparam logic [POOL_W-1:0]  RST_POOL_TAG   = 8'd1;
  localparam logic [CNT_W-1:0]   RST_SLOT_COUNT = 11'd1024;
  localparam logic [BYTES_W-1:0] RST_SLOT_BYTES = 13'd4;

endpackage

// ===== sv/fls_if.sv =====
// Request and response channel interfaces of the slot allocator.
interface fls_req_if;
  import fls_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [POOL_W-1:0] ref_pool;
  logic [SLOT_W-1:0] ref_slot;
  modport source(output valid, req_type, ref_pool, ref_slot, input ready);
  modport sink(input valid, req_type, ref_pool, ref_slot, output ready);
endinterface

interface fls_rsp_if;
  import fls_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POOL_W-1:0] out_pool;
  logic [SLOT_W-1:0] out_slot;
  logic [OFF_W-1:0]  byte_offset;
  logic [CNT_W-1:0]  free_left;
  modport source(output valid, status, out_pool, out_slot, byte_offset, free_left,
                 input ready);
  modport sink(input valid, status, out_pool, out_slot, byte_offset, free_left,
               output ready);
endinterface

// ===== sv/free_list_slot_allocator.sv =====
// Slot pool allocator: free list of slot indexes kept in a next-link memory.
//
// Requests arrive on req_i (valid/ready): allocate pops the free-list head,
// release checks the pool tag and pushes the slot, translate checks the tag
// and returns slot index times slot size. Each request gives one response
// on rsp_o (valid/ready) with status, reference, byte offset and free count.
// In the accept cycle the synchronous link memory reads the head's next
// link; the ST_EXEC state then evaluates the request in the shared
// compare/multiply step and loads the response register.
// The response register lets the next request be accepted while a result
// waits; if the receiver stalls longer, evaluation holds until it drains.
// Configuration (pool_tag, slot_count, slot_bytes) sits on an APB port at
// byte addresses 0, 4 and 8; pready is always high.
// After reset and after every register write the block rebuilds the list:
// a clearing pass writes entry i with i+1, one entry per cycle, over all
// POOL_DEPTH entries. Requests are not accepted during the pass; a write
// during the pass restarts it.
module free_list_slot_allocator #(
  parameter int unsigned POOL_DEPTH = fls_pkg::DEFAULT_POOL_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fls_req_if.sink                       req_i,
  fls_rsp_if.source                     rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fls_pkg::ADDR_W-1:0]    paddr,
  input  logic [fls_pkg::APB_DW-1:0]    pwdata,
  output logic [fls_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  import fls_pkg::*;

  localparam int unsigned IW = $clog2(POOL_DEPTH);
  localparam int unsigned LW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned CW = (LW > CNT_W) ? LW : CNT_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e             state_q;
  logic [IW-1:0]      clr_idx_q;
  logic [LW-1:0]      head_q;
  logic [CW-1:0]      free_q;

  logic [POOL_W-1:0]  pool_tag_q;
  logic [CNT_W-1:0]   slot_count_q;
  logic [BYTES_W-1:0] slot_bytes_q;

  logic [REQ_W-1:0]   req_type_q;
  logic [POOL_W-1:0]  ref_pool_q;
  logic [SLOT_W-1:0]  ref_slot_q;

  logic               out_valid_q;
  logic [STAT_W-1:0]  status_q;
  logic [POOL_W-1:0]  out_pool_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [OFF_W-1:0]   byte_offset_q;
  logic [CNT_W-1:0]   free_left_q;

  logic [LW-1:0]      link_rdata;

  // Effective capacity and slot size
  logic [CW-1:0]      cap;
  logic [BYTES_W-1:0] bytes_eff;

  always_comb begin
    cap = CW'(slot_count_q);
    if (cap == '0) begin
      cap = CW'(1);
    end else if (cap > CW'(POOL_DEPTH)) begin
      cap = CW'(POOL_DEPTH);
    end
    bytes_eff = (slot_bytes_q > BYTES_MAX) ? BYTES_MAX : slot_bytes_q;
  end

  // Configuration port
  logic              cfg_wr;
  logic [RIDX_W-1:0] cfg_idx;
  logic              cfg_hit;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:ADDR_W-RIDX_W];
  assign cfg_hit = cfg_wr && (cfg_idx == REG_POOL_TAG || cfg_idx == REG_SLOT_COUNT ||
                              cfg_idx == REG_SLOT_BYTES);
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      REG_POOL_TAG:   prdata = APB_DW'(pool_tag_q);
      REG_SLOT_COUNT: prdata = APB_DW'(slot_count_q);
      REG_SLOT_BYTES: prdata = APB_DW'(slot_bytes_q);
      default:        prdata = '0;
    endcase
  end

  // Handshakes
  logic req_fire;
  logic out_free;
  logic exec_go;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign exec_go     = (state_q == ST_EXEC) && out_free;

  // Shared evaluation step: tag/range compares, link pop or push, offset product
  logic              good_ref;
  logic [STAT_W-1:0] stat_c;
  logic [POOL_W-1:0] pool_c;
  logic [SLOT_W-1:0] slot_c;
  logic [OFF_W-1:0]  off_c;
  logic [LW-1:0]     head_c;
  logic [CW-1:0]     free_c;
  logic              push_c;

  always_comb begin
    good_ref = (ref_pool_q != '0) && (ref_pool_q == pool_tag_q) &&
               (CW'(ref_slot_q) < cap);
    stat_c   = STAT_BAD;
    pool_c   = '0;
    slot_c   = '0;
    off_c    = '0;
    head_c   = head_q;
    free_c   = free_q;
    push_c   = 1'b0;
    if (pool_tag_q == '0) begin
      stat_c = STAT_BAD;
    end else begin
      unique case (req_type_q)
        REQ_ALLOC: begin
          if (free_q == '0 || CW'(head_q) >= cap) begin
            stat_c = STAT_EMPTY;
          end else begin
            stat_c = STAT_OK;
            pool_c = pool_tag_q;
            slot_c = SLOT_W'(head_q);
            head_c = link_rdata;
            free_c = free_q - CW'(1);
          end
        end
        REQ_RELEASE: begin
          if (good_ref && free_q < cap) begin
            stat_c = STAT_OK;
            head_c = LW'(ref_slot_q);
            free_c = free_q + CW'(1);
            push_c = 1'b1;
          end
        end
        REQ_TRANSLATE: begin
          if (good_ref) begin
            stat_c = STAT_OK;
            off_c  = OFF_W'(ref_slot_q) * OFF_W'(bytes_eff);
          end
        end
        default: begin
          stat_c = STAT_BAD;
        end
      endcase
    end
  end

  // Link memory port selection: clearing pass or release push
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_q;
      ram_wdata = LW'(clr_idx_q) + LW'(1);
    end else begin
      ram_we    = exec_go && push_c;
      ram_waddr = IW'(ref_slot_q);
      ram_wdata = head_q;
    end
  end

  fls_link_ram #(
    .DEPTH (POOL_DEPTH),
    .AW    (IW),
    .DW    (LW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (IW'(head_q)),
    .rdata_o (link_rdata)
  );

  // Sequencer, list state, configuration and response registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_idx_q     <= '0;
      head_q        <= '0;
      free_q        <= '0;
      pool_tag_q    <= RST_POOL_TAG;
      slot_count_q  <= RST_SLOT_COUNT;
      slot_bytes_q  <= RST_SLOT_BYTES;
      req_type_q    <= REQ_ALLOC;
      ref_pool_q    <= '0;
      ref_slot_q    <= '0;
      out_valid_q   <= 1'b0;
      status_q      <= STAT_OK;
      out_pool_q    <= '0;
      out_slot_q    <= '0;
      byte_offset_q <= '0;
      free_left_q   <= '0;
    end else begin
      // drop the response once taken, unless a new one loads in the same cycle
      if (out_valid_q && rsp_o.ready && !(exec_go && !cfg_hit)) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_hit) begin
        unique case (cfg_idx)
          REG_POOL_TAG:   pool_tag_q   <= pwdata[POOL_W-1:0];
          REG_SLOT_COUNT: slot_count_q <= pwdata[CNT_W-1:0];
          REG_SLOT_BYTES: slot_bytes_q <= pwdata[BYTES_W-1:0];
          default:        pool_tag_q   <= pool_tag_q;
        endcase
        state_q   <= ST_CLEAR;
        clr_idx_q <= '0;
      end else begin
        unique case (state_q)
          ST_CLEAR: begin
            // advance the rebuild sweep, then open the list
            clr_idx_q <= clr_idx_q + IW'(1);
            if (clr_idx_q == IW'(POOL_DEPTH - 1)) begin
              head_q  <= '0;
              free_q  <= cap;
              state_q <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (req_fire) begin
              req_type_q <= req_i.req_type;
              ref_pool_q <= req_i.ref_pool;
              ref_slot_q <= req_i.ref_slot;
              state_q    <= ST_EXEC;
            end
          end
          ST_EXEC: begin
            // hold until the response register can take the result
            if (out_free) begin
              head_q        <= head_c;
              free_q        <= free_c;
              out_valid_q   <= 1'b1;
              status_q      <= stat_c;
              out_pool_q    <= pool_c;
              out_slot_q    <= slot_c;
              byte_offset_q <= off_c;
              free_left_q   <= CNT_W'(free_c);
              state_q       <= ST_IDLE;
            end
          end
          default: begin
            state_q <= ST_CLEAR;
          end
        endcase
      end
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.out_pool    = out_pool_q;
  assign rsp_o.out_slot    = out_slot_q;
  assign rsp_o.byte_offset = byte_offset_q;
  assign rsp_o.free_left   = free_left_q;

endmodule

// ===== sv/fls_link_ram.sv =====
// Next-link memory: one write port, one read port with registered read data.
module fls_link_ram #(
  parameter int unsigned DEPTH = fls_pkg::DEFAULT_POOL_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fls_checker.sv =====
// Port-level checks for the slot allocator, bound to its top level.
module fls_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [fls_pkg::STAT_W-1:0]  status,
  input logic [fls_pkg::POOL_W-1:0]  out_pool,
  input logic [fls_pkg::SLOT_W-1:0]  out_slot,
  input logic [fls_pkg::OFF_W-1:0]   byte_offset
);

  import fls_pkg::*;

  // One request at a time: ready drops after an accepted transaction
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted in back-to-back cycles");

  // A stalled response holds its status
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
    else $error("stalled response changed");

  // Failed requests carry a null reference and no offset
  a_fail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && status != STAT_OK |->
      out_pool == '0 && out_slot == '0 && byte_offset == '0)
    else $error("failed response carries a reference or offset");

  // Status is always a defined code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> status == STAT_OK || status == STAT_EMPTY || status == STAT_BAD)
    else $error("undefined status code");

endmodule

bind free_list_slot_allocator fls_checker u_fls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid   (req_i.valid),
  .req_ready   (req_i.ready),
  .rsp_valid   (rsp_o.valid),
  .rsp_ready   (rsp_o.ready),
  .status      (rsp_o.status),
  .out_pool    (rsp_o.out_pool),
  .out_slot    (rsp_o.out_slot),
  .byte_offset (rsp_o.byte_offset)
);

// ===== sim/free_list_slot_allocator_tb.sv =====
// Self-checking testbench for the free-list slot allocator: directed table, then random phases.
module free_list_slot_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fls_pkg::*;

  localparam int unsigned DEPTH     = DEFAULT_POOL_DEPTH;
  localparam int unsigned PHASES    = 12;
  localparam int unsigned LONG_HOLD = 300;

  // Request code that the block does not define
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [POOL_W-1:0] pool;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POOL_W-1:0] pool;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  offset;
    logic [CNT_W-1:0]  free_left;
  } rsp_t;

  // One line of the directed plan: a register write or a request
  typedef struct packed {
    bit                is_cfg;
    logic [RIDX_W-1:0] reg_idx;
    logic [31:0]       reg_val;
    req_t              rq;
    bit                typed;
    rsp_t              want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  logic pready;

  fls_req_if req_ch();
  fls_rsp_if rsp_ch();

  free_list_slot_allocator DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the pool: link memory, head, free count and registers
  logic [CNT_W-1:0]   link_mem [DEPTH];
  logic [CNT_W-1:0]   list_head;
  logic [CNT_W-1:0]   shadow_free;
  logic [POOL_W-1:0]  cfg_tag;
  logic [CNT_W-1:0]   cfg_count;
  logic [BYTES_W-1:0] cfg_bytes;

  rsp_t        expect_q [$];
  int unsigned held_slots [$];
  int unsigned fault_count = 0;
  int unsigned sent_count = 0;
  int unsigned seen_count = 0;
  int unsigned ok_allocs = 0;
  int unsigned empty_count = 0;
  int unsigned bad_count = 0;
  int unsigned write_count = 0;

  // Receiver controls: stall pattern and long hold-off request
  logic [15:0] stall_pat = '0;
  bit          hold_req = 1'b0;

  function automatic int unsigned pool_cap();
    int unsigned c;
    c = cfg_count;
    if (c < 1) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic int unsigned slot_size();
    return (cfg_bytes > BYTES_MAX) ? int'(BYTES_MAX) : int'(cfg_bytes);
  endfunction

  function automatic void rebuild_list();
    for (int i = 0; i < DEPTH; i++) link_mem[i] = CNT_W'(i + 1);
    list_head   = '0;
    shadow_free = CNT_W'(pool_cap());
  endfunction

  // Work out the response to one request and advance the shadow pool
  function automatic rsp_t predict_req(req_t r);
    rsp_t        o;
    int unsigned cap;
    bit          ref_ok;
    o        = '0;
    o.status = STAT_BAD;
    cap      = pool_cap();
    ref_ok   = (r.pool != 0) && (r.pool == cfg_tag) && (r.slot < cap);
    if (cfg_tag != 0) begin
      case (r.kind)
        REQ_ALLOC: begin
          if (shadow_free == 0 || list_head >= cap) begin
            o.status = STAT_EMPTY;
          end else begin
            o.status    = STAT_OK;
            o.pool      = cfg_tag;
            o.slot      = list_head[SLOT_W-1:0];
            list_head   = link_mem[list_head];
            shadow_free = shadow_free - 1'b1;
          end
        end
        REQ_RELEASE: begin
          if (ref_ok && shadow_free < cap) begin
            link_mem[r.slot] = list_head;
            list_head        = CNT_W'(r.slot);
            shadow_free      = shadow_free + 1'b1;
            o.status         = STAT_OK;
          end
        end
        REQ_TRANSLATE: begin
          if (ref_ok) begin
            o.status = STAT_OK;
            o.offset = OFF_W'(int'(r.slot) * slot_size());
          end
        end
        default: ;
      endcase
    end
    o.free_left = shadow_free;
    return o;
  endfunction

  // Mostly well-formed traffic on live slots, with some noise mixed in
  function automatic req_t random_req();
    req_t        r;
    int unsigned pick, idx, cap;
    cap    = pool_cap();
    pick   = $urandom_range(0, 99);
    r      = '0;
    r.kind = REQ_ALLOC;
    r.pool = POOL_W'($urandom_range(0, 255));
    r.slot = SLOT_W'($urandom_range(0, 1023));
    if (pick >= 40 && pick < 70 && held_slots.size() > 0) begin
      idx    = $urandom_range(0, held_slots.size() - 1);
      r.kind = REQ_RELEASE;
      r.pool = cfg_tag;
      r.slot = SLOT_W'(held_slots[idx]);
      held_slots.delete(idx);
    end else if (pick >= 70 && pick < 85) begin
      r.kind = REQ_TRANSLATE;
      r.pool = cfg_tag;
      r.slot = SLOT_W'($urandom_range(0, cap - 1));
    end else if (pick >= 85) begin
      r.kind = REQ_W'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) r.pool = cfg_tag;
      if ($urandom_range(0, 1)) r.slot = SLOT_W'($urandom_range(0, cap - 1));
    end
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [RIDX_W-1:0] idx, int unsigned val);
    plan_row_t p;
    p         = '0;
    p.is_cfg  = 1'b1;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  function automatic plan_row_t item_row(logic [REQ_W-1:0] kind, int unsigned pool,
                                         int unsigned slot);
    plan_row_t p;
    p         = '0;
    p.rq.kind = kind;
    p.rq.pool = POOL_W'(pool);
    p.rq.slot = SLOT_W'(slot);
    return p;
  endfunction

  function automatic plan_row_t typed_row(logic [REQ_W-1:0] kind, int unsigned pool,
                                          int unsigned slot, logic [STAT_W-1:0] status,
                                          int unsigned opool, int unsigned oslot,
                                          int unsigned offset, int unsigned left);
    plan_row_t p;
    p                = item_row(kind, pool, slot);
    p.typed          = 1'b1;
    p.want.status    = status;
    p.want.pool      = POOL_W'(opool);
    p.want.slot      = SLOT_W'(oslot);
    p.want.offset    = OFF_W'(offset);
    p.want.free_left = CNT_W'(left);
    return p;
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic send_item(req_t r, bit typed, rsp_t want);
    rsp_t pred;
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= r.kind;
    req_ch.ref_pool <= r.pool;
    req_ch.ref_slot <= r.slot;
    do @(posedge clk); while (!req_ch.ready);
    pred = predict_req(r);
    if (r.kind == REQ_ALLOC && pred.status == STAT_OK) held_slots.push_back(pred.slot);
    expect_q.push_back(typed ? want : pred);
    sent_count++;
  endtask

  // Drop valid and wait until every outstanding response has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup phase, then access phase until pready, then back to idle
  task automatic reg_write(logic [RIDX_W-1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_POOL_TAG:   cfg_tag   = val[POOL_W-1:0];
      REG_SLOT_COUNT: cfg_count = val[CNT_W-1:0];
      REG_SLOT_BYTES: cfg_bytes = val[BYTES_W-1:0];
      default: ;
    endcase
    rebuild_list();
    held_slots.delete();
    write_count++;
    @(posedge clk);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got, bit bad);
    if (bad) begin
      fault_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: rotate a stall pattern, or hold off for a long stretch on request
  initial begin
    int unsigned hold_left;
    int unsigned rot;
    hold_left = 0;
    rot       = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rot = (rot + 1) % 16;
        rsp_ch.ready <= rst_n && !stall_pat[rot];
      end
    end
  end

  // Compare every response transaction with the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (expect_q.size() == 0) begin
        fault_count++;
        $display("%0t ns: response with none expected, status %0d slot %0d", $time,
                 rsp_ch.status, rsp_ch.out_slot);
      end else begin
        want = expect_q.pop_front();
        seen_count++;
        case (want.status)
          STAT_OK:    if (want.pool != 0) ok_allocs++;
          STAT_EMPTY: empty_count++;
          default:    bad_count++;
        endcase
        check_field("status", want.status, rsp_ch.status, rsp_ch.status !== want.status);
        check_field("out_pool", want.pool, rsp_ch.out_pool, rsp_ch.out_pool !== want.pool);
        check_field("out_slot", want.slot, rsp_ch.out_slot, rsp_ch.out_slot !== want.slot);
        check_field("byte_offset", want.offset, rsp_ch.byte_offset,
                    rsp_ch.byte_offset !== want.offset);
        check_field("free_left", want.free_left, rsp_ch.free_left,
                    rsp_ch.free_left !== want.free_left);
      end
    end
  end

  // Run limit
  initial begin
    #6ms;
    $display("free_list_slot_allocator verification failed");
    $finish;
  end

  // Stimulus
  initial begin
    plan_row_t   plan [$];
    plan_row_t   row;
    int unsigned items, burst_left, gap, waited;
    bit          gapless;
    rst_n           <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_ALLOC;
    req_ch.ref_pool <= '0;
    req_ch.ref_slot <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    cfg_tag   = RST_POOL_TAG;
    cfg_count = RST_SLOT_COUNT;
    cfg_bytes = RST_SLOT_BYTES;
    rebuild_list();
    stall_pat = 16'($urandom) & 16'hFFFE;

    // Directed table: reset state, small pool, clamps, disabled pool, extremes
    plan = '{
      typed_row(REQ_ALLOC, 0, 0, STAT_OK, 1, 0, 0, 1023),
      typed_row(REQ_ALLOC, 0, 0, STAT_OK, 1, 1, 0, 1022),
      typed_row(REQ_TRANSLATE, 1, 1023, STAT_OK, 0, 0, 4092, 1022),
      typed_row(REQ_TRANSLATE, 0, 5, STAT_BAD, 0, 0, 0, 1022),
      typed_row(REQ_TRANSLATE, 255, 0, STAT_BAD, 0, 0, 0, 1022),
      typed_row(REQ_RELEASE, 1, 0, STAT_OK, 0, 0, 0, 1023),
      typed_row(REQ_RELEASE, 2, 1, STAT_BAD, 0, 0, 0, 1023),
      typed_row(REQ_UNKNOWN, 0, 0, STAT_BAD, 0, 0, 0, 1023),
      typed_row(REQ_RELEASE, 1, 1, STAT_OK, 0, 0, 0, 1024),
      typed_row(REQ_RELEASE, 1, 5, STAT_BAD, 0, 0, 0, 1024),
      cfg_row(REG_SLOT_COUNT, 2),
      typed_row(REQ_ALLOC, 0, 0, STAT_OK, 1, 0, 0, 1),
      typed_row(REQ_ALLOC, 255, 1023, STAT_OK, 1, 1, 0, 0),
      typed_row(REQ_ALLOC, 0, 0, STAT_EMPTY, 0, 0, 0, 0),
      typed_row(REQ_TRANSLATE, 1, 2, STAT_BAD, 0, 0, 0, 0),
      typed_row(REQ_RELEASE, 1, 1023, STAT_BAD, 0, 0, 0, 0),
      item_row(REQ_RELEASE, 1, 1),
      cfg_row(REG_SLOT_BYTES, 8191),
      typed_row(REQ_TRANSLATE, 1, 1, STAT_OK, 0, 0, 4096, 2),
      cfg_row(REG_SLOT_COUNT, 0),
      typed_row(REQ_ALLOC, 0, 0, STAT_OK, 1, 0, 0, 0),
      typed_row(REQ_ALLOC, 0, 0, STAT_EMPTY, 0, 0, 0, 0),
      cfg_row(REG_POOL_TAG, 0),
      typed_row(REQ_ALLOC, 0, 0, STAT_BAD, 0, 0, 0, 1),
      typed_row(REQ_TRANSLATE, 0, 0, STAT_BAD, 0, 0, 0, 1),
      typed_row(REQ_RELEASE, 0, 0, STAT_BAD, 0, 0, 0, 1),
      item_row(REQ_UNKNOWN, 255, 1023),
      cfg_row(REG_POOL_TAG, 255),
      cfg_row(REG_SLOT_COUNT, 2047),
      cfg_row(REG_SLOT_BYTES, 4096),
      typed_row(REQ_TRANSLATE, 255, 1023, STAT_OK, 0, 0, 4190208, 1024),
      typed_row(REQ_ALLOC, 0, 0, STAT_OK, 255, 0, 0, 1023),
      typed_row(REQ_RELEASE, 255, 0, STAT_OK, 0, 0, 0, 1024),
      item_row(REQ_RELEASE, 255, 1),
      cfg_row(REG_SLOT_BYTES, 0),
      item_row(REQ_TRANSLATE, 255, 7)
    };

    // Hold reset, then walk the table
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        drain();
        reg_write(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.rq, row.typed, row.want);
      end
    end

    // Random phases, each with its own register setting and idle behavior
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       reg_write(REG_POOL_TAG, 255);
        1:       reg_write(REG_POOL_TAG, 1);
        3:       reg_write(REG_POOL_TAG, 0);
        default: reg_write(REG_POOL_TAG, $urandom_range(1, 255));
      endcase
      case (p % 6)
        0:       reg_write(REG_SLOT_COUNT, 2047);
        1:       reg_write(REG_SLOT_COUNT, 0);
        2:       reg_write(REG_SLOT_COUNT, $urandom_range(1, 8));
        3:       reg_write(REG_SLOT_COUNT, $urandom_range(1, 1024));
        4:       reg_write(REG_SLOT_COUNT, 1024);
        default: reg_write(REG_SLOT_COUNT, $urandom_range(2, 16));
      endcase
      case (p % 5)
        0:       reg_write(REG_SLOT_BYTES, 8191);
        1:       reg_write(REG_SLOT_BYTES, 0);
        2:       reg_write(REG_SLOT_BYTES, 4096);
        3:       reg_write(REG_SLOT_BYTES, 1);
        default: reg_write(REG_SLOT_BYTES, $urandom_range(0, 8191));
      endcase
      stall_pat  = (p % 3 == 0) ? 16'h0000 : (16'($urandom) & 16'hFFFE);
      gapless    = (p == 2 || p == 8 || p == 5);
      burst_left = $urandom_range(1, 24);
      items      = (p == 3) ? 30 : 135;
      for (int n = 0; n < items; n++) begin
        send_item(random_req(), 1'b0, '0);
        // Stall the receiver long enough for the block to back up
        if (p == 5 && n == 20) hold_req = 1'b1;
        // Let the pipeline run dry in the middle of a phase
        if (p == 7 && n == 60) begin
          drain();
        end else begin
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = gapless ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
              req_ch.valid <= 1'b0;
              repeat (gap) @(posedge clk);
            end
          end
        end
      end
    end

    // Wait out the last responses, bounded
    req_ch.valid <= 1'b0;
    waited = 0;
    while (expect_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expect_q.size() != 0) begin
      $display("%0t ns: %0d expected responses never arrived", $time, expect_q.size());
      fault_count += expect_q.size();
    end

    $display("Covered %0d requests over %0d register writes: %0d grants, %0d empty, %0d rejected",
             sent_count, write_count, ok_allocs, empty_count, bad_count);
    $display("Compared %0d responses, %0d field mismatches", seen_count, fault_count);
    if (fault_count == 0) begin
      $display("free_list_slot_allocator verification clean");
    end else begin
      $display("free_list_slot_allocator verification failed");
    end
    $finish;
  end

endmodule
